FILE: design/tccw_pkg.sv
// Package for the text console character writer: sizes, character codes,
// register map, the request record passed from front to back, and state types.
// Depends on nothing; every design file but tccw_ram refers to it by scoped names.
package tccw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    // Fixed field widths of the channels.
    localparam int ADDR_W = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int DATA_W = 16;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STYLE = '0;
    localparam logic [ATTR_W-1:0] STYLE_RESET = 8'd7;

    // Command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Action that the back part carries out for a request.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_READ,
        OP_CLEAR
    } op_kind_t;

    // Result fields of one request.
    typedef struct packed {
        logic [ADDR_W-1:0] cursor_position;
        logic              cell_written;
        logic [ADDR_W-1:0] cell_address;
        logic [DATA_W-1:0] cell_data;
        logic              screen_cleared;
    } res_t;

    // Classified request as queued between front and back.
    typedef struct packed {
        op_kind_t          kind;
        logic              in_range;
        logic [DATA_W-1:0] blank;
        res_t              res;
    } op_t;

    // Screen store access from the back part.
    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [DATA_W-1:0]  wdata;
        logic [CELL_AW-1:0] raddr;
    } ram_req_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CLEAR,
        B_DONE
    } back_state_t;

    // Build a screen cell from an attribute and a character.
    function automatic logic [DATA_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                    input logic [CHAR_W-1:0] ch);
        return {attr, ch};
    endfunction

endpackage

FILE: design/text_console_char_writer.sv
// Top level of the text console character writer: configuration port, front,
// request queue, back and screen store. Depends on tccw_pkg and all tccw_ modules.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    cmd, char_code, read_address
//   m_        out        m_valid/m_ready    cursor_position, cell_written,
//                                           cell_address, cell_data, screen_cleared
//   APB       in         psel/penable       style_attribute at byte address 0
//
// A character, tab or backspace request is carried out in the idle state of the
// back part; a read goes on to B_READ for the registered read of the screen store.
// A request that wraps past the last row sweeps the store one cell a cycle,
// then loads its result in B_DONE.
// The front accepts up to two requests ahead of the back part. A result held in
// the output register stalls the back part until m_ready, and once the queue
// is full s_ready drops.
// Reset homes the cursor, empties the queue and sets the style to its reset
// value; the store is not cleared.
module text_console_char_writer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [tccw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tccw_pkg::ADDR_W-1:0]    s_read_address,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tccw_pkg::ADDR_W-1:0]    m_cursor_position,
    output logic                           m_cell_written,
    output logic [tccw_pkg::ADDR_W-1:0]    m_cell_address,
    output logic [tccw_pkg::DATA_W-1:0]    m_cell_data,
    output logic                           m_screen_cleared,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [tccw_pkg::ATTR_W-1:0]    style_reg;
    logic [tccw_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           push, q_full, q_valid, q_pop;
    tccw_pkg::op_t                  push_op, head;
    tccw_pkg::ram_req_t             ram_req;
    logic [tccw_pkg::DATA_W-1:0]    ram_rdata;
    tccw_pkg::res_t                 m_res;

    // Configuration register.
    assign reg_idx = paddr[tccw_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == tccw_pkg::REG_STYLE) ? tccw_pkg::PDATA_W'(style_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg <= tccw_pkg::STYLE_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_idx == tccw_pkg::REG_STYLE) begin
            style_reg <= pwdata[tccw_pkg::ATTR_W-1:0];
        end
    end

    // Front part.
    tccw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_char_code    (s_char_code),
        .s_read_address (s_read_address),
        .style          (style_reg),
        .q_full         (q_full),
        .push           (push),
        .push_op        (push_op)
    );

    // Request queue.
    tccw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .q_valid (q_valid),
        .head    (head),
        .pop     (q_pop)
    );

    // Back part.
    tccw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .head      (head),
        .q_pop     (q_pop),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    // Screen store.
    tccw_ram #(
        .WIDTH (tccw_pkg::DATA_W),
        .DEPTH (tccw_pkg::CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign m_cursor_position = m_res.cursor_position;
    assign m_cell_written    = m_res.cell_written;
    assign m_cell_address    = m_res.cell_address;
    assign m_cell_data       = m_res.cell_data;
    assign m_screen_cleared  = m_res.screen_cleared;

    // The store is never written beyond the screen.
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (32'(ram_req.waddr) < 32'(tccw_pkg::CELL_COUNT)))
        else $error("screen store written beyond the last cell");

    // The reported cursor always lies on the screen.
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_position) < 32'(tccw_pkg::CELL_COUNT)))
        else $error("cursor position beyond the screen");

    // A screen clear always returns the cursor to the top left cell.
    a_clear_homes_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_screen_cleared) |-> (m_cursor_position == '0))
        else $error("screen cleared without homing the cursor");

    // A character that causes a clear can only have been reported written to the last cell.
    a_clear_after_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_screen_cleared && m_cell_written)
        |-> (m_cell_address == tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - 1)))
        else $error("clear after a write that was not in the last cell");

endmodule

FILE: design/tccw_ram.sv
// Generic single-port-write, single-port-read memory with a registered read.
// Depends on nothing.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tccw_front.sv
// Front part: accepts requests, keeps the cursor and classifies each request
// into an action for the back part. Depends on tccw_pkg.
module tccw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [tccw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tccw_pkg::ADDR_W-1:0]   s_read_address,
    input  logic [tccw_pkg::ATTR_W-1:0]   style,
    input  logic                          q_full,
    output logic                          push,
    output tccw_pkg::op_t                 push_op
);

    logic [tccw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tccw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tccw_pkg::CELL_AW-1:0] base_reg, base_next;
    logic [tccw_pkg::CELL_AW-1:0] pos_reg, pos_next;

    // What a newline would do from the present row.
    logic                         nl_clear;
    logic [tccw_pkg::ROW_W-1:0]   nl_row;
    logic [tccw_pkg::CELL_AW-1:0] nl_base;

    assign nl_clear = (row_reg == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
    assign nl_row   = nl_clear ? '0 : row_reg + 1'b1;
    assign nl_base  = nl_clear ? '0 : base_reg + tccw_pkg::CELL_AW'(tccw_pkg::COLUMNS);

    // A request is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Classify the request and work out the cursor after it.
    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        base_next = base_reg;
        pos_next  = pos_reg;

        push_op.kind                = tccw_pkg::OP_NOP;
        push_op.in_range            = 1'b0;
        push_op.blank               = tccw_pkg::make_cell(style, tccw_pkg::CH_SPACE);
        push_op.res.cell_written    = 1'b0;
        push_op.res.cell_address    = '0;
        push_op.res.cell_data       = '0;
        push_op.res.screen_cleared  = 1'b0;

        if (s_cmd == tccw_pkg::CMD_READ) begin
            push_op.kind             = tccw_pkg::OP_READ;
            push_op.in_range         = (32'(s_read_address) < 32'(tccw_pkg::CELL_COUNT));
            push_op.res.cell_address = s_read_address;
        end else begin
            case (s_char_code)
                tccw_pkg::CH_NEWLINE: begin
                    row_next  = nl_row;
                    col_next  = '0;
                    base_next = nl_base;
                    pos_next  = nl_base;
                    if (nl_clear) begin
                        push_op.kind               = tccw_pkg::OP_CLEAR;
                        push_op.res.screen_cleared = 1'b1;
                    end
                end
                tccw_pkg::CH_TAB: begin
                    // Tab leaves everything as it is.
                end
                tccw_pkg::CH_BACKSPACE: begin
                    if (col_reg != '0) begin
                        col_next                 = col_reg - 1'b1;
                        pos_next                 = pos_reg - 1'b1;
                        push_op.kind             = tccw_pkg::OP_WRITE;
                        push_op.res.cell_written = 1'b1;
                        push_op.res.cell_address = tccw_pkg::ADDR_W'(pos_next);
                        push_op.res.cell_data    = push_op.blank;
                    end
                end
                default: begin
                    push_op.kind             = tccw_pkg::OP_WRITE;
                    push_op.res.cell_written = 1'b1;
                    push_op.res.cell_address = tccw_pkg::ADDR_W'(pos_reg);
                    push_op.res.cell_data    = tccw_pkg::make_cell(style, s_char_code);
                    if (col_reg == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1)) begin
                        // Last column: the cursor moves to the next row.
                        row_next  = nl_row;
                        col_next  = '0;
                        base_next = nl_base;
                        pos_next  = nl_base;
                        if (nl_clear) begin
                            // The character is not stored; the sweep blanks its cell with the rest.
                            push_op.kind               = tccw_pkg::OP_CLEAR;
                            push_op.res.screen_cleared = 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
            endcase
        end

        push_op.res.cursor_position = tccw_pkg::ADDR_W'(pos_next);
    end

    // Cursor registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
            pos_reg  <= '0;
        end else if (push) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

FILE: design/tccw_queue.sv
// Short request queue between the front and back parts.
// Depends on tccw_pkg.
module tccw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tccw_pkg::op_t push_op,
    output logic          full,
    output logic          q_valid,
    output tccw_pkg::op_t head,
    input  logic          pop
);

    tccw_pkg::op_t               entry_reg [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tccw_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tccw_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    assign full    = (count_reg == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: design/tccw_back.sv
// Back part: carries out queued requests on the screen store (write, read,
// whole-screen clear) and holds the result register. Depends on tccw_pkg.
module tccw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  tccw_pkg::op_t                 head,
    output logic                          q_pop,
    output tccw_pkg::ram_req_t            ram_req,
    input  logic [tccw_pkg::DATA_W-1:0]   ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tccw_pkg::res_t                m_res
);

    tccw_pkg::back_state_t        state_reg, state_next;
    tccw_pkg::op_t                cur_reg;
    logic [tccw_pkg::CELL_AW-1:0] cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    tccw_pkg::res_t               out_reg;
    logic                         out_free;
    logic                         load;
    logic                         capture;
    tccw_pkg::res_t               load_res;
    logic                         sweep_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_last = (cnt_reg == tccw_pkg::CELL_AW'(tccw_pkg::CELL_COUNT - 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::B_IDLE: begin
                if (q_valid && head.kind == tccw_pkg::OP_READ) begin
                    state_next = tccw_pkg::B_READ;
                end else if (q_valid && head.kind == tccw_pkg::OP_CLEAR) begin
                    state_next = tccw_pkg::B_CLEAR;
                end
            end
            tccw_pkg::B_READ: begin
                if (out_free) begin
                    state_next = tccw_pkg::B_IDLE;
                end
            end
            tccw_pkg::B_CLEAR: begin
                if (sweep_last) begin
                    state_next = tccw_pkg::B_DONE;
                end
            end
            tccw_pkg::B_DONE: begin
                if (out_free) begin
                    state_next = tccw_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = tccw_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: queue pop, store access and result load.
    always_comb begin
        q_pop    = 1'b0;
        ram_req  = '0;
        load     = 1'b0;
        capture  = 1'b0;
        load_res = head.res;
        cnt_next = cnt_reg;
        case (state_reg)
            tccw_pkg::B_IDLE: begin
                if (q_valid) begin
                    case (head.kind)
                        tccw_pkg::OP_NOP: begin
                            if (out_free) begin
                                q_pop = 1'b1;
                                load  = 1'b1;
                            end
                        end
                        tccw_pkg::OP_WRITE: begin
                            if (out_free) begin
                                q_pop         = 1'b1;
                                load          = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = tccw_pkg::CELL_AW'(head.res.cell_address);
                                ram_req.wdata = head.res.cell_data;
                            end
                        end
                        tccw_pkg::OP_READ: begin
                            q_pop         = 1'b1;
                            capture       = 1'b1;
                            ram_req.raddr = head.in_range
                                            ? tccw_pkg::CELL_AW'(head.res.cell_address) : '0;
                        end
                        tccw_pkg::OP_CLEAR: begin
                            q_pop    = 1'b1;
                            capture  = 1'b1;
                            cnt_next = '0;
                        end
                        default: begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            tccw_pkg::B_READ: begin
                // Keep the read address so the registered data stays put.
                ram_req.raddr = cur_reg.in_range
                                ? tccw_pkg::CELL_AW'(cur_reg.res.cell_address) : '0;
                load_res           = cur_reg.res;
                load_res.cell_data = cur_reg.in_range ? ram_rdata : '0;
                load               = out_free;
            end
            tccw_pkg::B_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cnt_reg;
                ram_req.wdata = cur_reg.blank;
                cnt_next      = cnt_reg + 1'b1;
            end
            tccw_pkg::B_DONE: begin
                load_res = cur_reg.res;
                load     = out_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // Result register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tccw_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (capture) begin
            cur_reg <= head;
        end
        if (load) begin
            out_reg <= load_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

endmodule
